/* rtl/core/dofq_pkg.sv */
// Package for the drop-oldest frame queue: constants, word types, opcodes,
// controller states and the command/status bundles between controller and datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package dofq_pkg;

   // Default sizing
   localparam int DEPTH_DEF         = 16;
   localparam int PAYLOAD_BYTES_DEF = 8;

   // Fixed field widths
   localparam int STREAM_W = 8;
   localparam int SEQ_W    = 16;
   localparam int TIME_W   = 64;
   localparam int LEN_W    = 4;
   localparam int DATA_W   = 64;
   localparam int FILL_W   = 5;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_PURGE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_WALK,
      ST_PURGE_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [STREAM_W-1:0] stream_tag;
      logic [SEQ_W-1:0]    seq_num;
      logic [TIME_W-1:0]   time_stamp;
      logic [LEN_W-1:0]    pay_len;
      logic [DATA_W-1:0]   pay_data;
   } req_type;

   typedef struct packed {
      logic                ok;
      logic                dropped_oldest;
      logic [STREAM_W-1:0] out_stream;
      logic [SEQ_W-1:0]    out_seq;
      logic [TIME_W-1:0]   out_time;
      logic [LEN_W-1:0]    out_len;
      logic [DATA_W-1:0]   out_data;
      logic [FILL_W-1:0]   fill;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic latch_req;
      logic push_commit;
      logic read_issue;
      logic read_commit;
      logic walk_start;
      logic walk_step;
      logic purge_commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   walk_more;
      logic   walk_pend;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/core/dofq_ctrl.sv */
// Controller for the drop-oldest frame queue: sequences each request word
// through execute, read and purge-walk steps and owns the response valid flag.
// Depends on dofq_pkg.
`default_nettype none

module dofq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire dofq_pkg::sts_type sts,
   output dofq_pkg::cmd_type      cmd
);
   import dofq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      commit;

   // Output register can take a word when empty or being drained
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (sts.op)
               OP_PUSH:  if (slot_free) state_in = ST_IDLE;
               OP_POP:   state_in = ST_READ;
               OP_PEEK:  state_in = ST_READ;
               OP_PURGE: state_in = ST_WALK;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_READ: begin
            if (slot_free) state_in = ST_IDLE;
         end
         ST_WALK: begin
            if (!sts.walk_more && !sts.walk_pend) state_in = ST_PURGE_DONE;
         end
         ST_PURGE_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.latch_req = req_valid;
         end
         ST_EXEC: begin
            unique case (sts.op)
               OP_PUSH:  cmd.push_commit = slot_free;
               OP_POP:   cmd.read_issue  = 1'b1;
               OP_PEEK:  cmd.read_issue  = 1'b1;
               OP_PURGE: cmd.walk_start  = 1'b1;
               default:  cmd = '0;
            endcase
         end
         ST_READ: begin
            cmd.read_commit = slot_free;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
         end
         ST_PURGE_DONE: begin
            cmd.purge_commit = slot_free;
         end
         default: cmd = '0;
      endcase
   end

   // Response valid: set on a commit, drop once the word is taken
   assign commit       = cmd.push_commit || cmd.read_commit || cmd.purge_commit;
   assign rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dofq_dp.sv */
// Datapath for the drop-oldest frame queue: frame memory, ring pointers,
// fill count, purge compaction counters and the response register.
// Depends on dofq_pkg; driven by dofq_ctrl commands.
`default_nettype none

module dofq_dp #(
   parameter int DEPTH         = dofq_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BYTES = dofq_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dofq_pkg::req_type req_data,
   input  wire dofq_pkg::cmd_type cmd,
   output dofq_pkg::sts_type      sts,
   output dofq_pkg::rsp_type      rsp_data
);
   import dofq_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = PAYLOAD_BYTES * 8;

   typedef struct packed {
      logic [STREAM_W-1:0] stream;
      logic [SEQ_W-1:0]    seq;
      logic [TIME_W-1:0]   stamp;
      logic [LEN_W-1:0]    len;
      logic [DW-1:0]       data;
   } frame_type;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      logic [PW-1:0] n;
      n = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
      return n;
   endfunction

   frame_type     mem [DEPTH];
   frame_type     rd_word_ff;
   req_type       req_ff;
   rsp_type       rsp_ff, rsp_in;

   logic [PW-1:0] write_ptr_ff, write_ptr_in;
   logic [PW-1:0] read_ptr_ff,  read_ptr_in;
   logic [CW-1:0] held_ff,      held_in;
   logic [PW-1:0] rd_addr_ff,   rd_addr_in;
   logic [PW-1:0] wr_addr_ff,   wr_addr_in;
   logic [CW-1:0] rd_cnt_ff,    rd_cnt_in;
   logic [CW-1:0] kept_ff,      kept_in;
   logic          pend_ff,      pend_in;

   logic          mem_we, mem_re;
   logic [PW-1:0] mem_wa, mem_ra;
   frame_type     mem_wd;
   frame_type     push_word;
   logic [DW-1:0] push_data;
   logic          push_ok, full, walk_more, walk_keep;

   // Clip payload bytes beyond the length
   always_comb begin
      push_data = '0;
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         if (LEN_W'(b) < req_ff.pay_len) push_data[b*8 +: 8] = req_ff.pay_data[b*8 +: 8];
      end
   end

   assign push_word = '{stream: req_ff.stream_tag, seq: req_ff.seq_num,
                        stamp: req_ff.time_stamp, len: req_ff.pay_len, data: push_data};
   assign push_ok   = (req_ff.pay_len <= LEN_W'(PAYLOAD_BYTES));
   assign full      = (held_ff == CW'(DEPTH));
   assign walk_more = (rd_cnt_ff != held_ff);
   assign walk_keep = pend_ff && (rd_word_ff.stream != req_ff.stream_tag);

   assign sts = '{op: op_type'(req_ff.op), walk_more: walk_more, walk_pend: pend_ff};

   // Memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = write_ptr_ff;
      mem_wd = push_word;
      mem_re = 1'b0;
      mem_ra = read_ptr_ff;
      if (cmd.push_commit && push_ok) begin
         mem_we = 1'b1;
      end else if (cmd.walk_step && walk_keep) begin
         mem_we = 1'b1;
         mem_wa = wr_addr_ff;
         mem_wd = rd_word_ff;
      end
      if (cmd.read_issue) begin
         mem_re = 1'b1;
      end else if (cmd.walk_step && walk_more) begin
         mem_re = 1'b1;
         mem_ra = rd_addr_ff;
      end
   end

   // Pointers, fill, walk counters and response word
   always_comb begin
      write_ptr_in = write_ptr_ff;
      read_ptr_in  = read_ptr_ff;
      held_in      = held_ff;
      rd_addr_in   = rd_addr_ff;
      wr_addr_in   = wr_addr_ff;
      rd_cnt_in    = rd_cnt_ff;
      kept_in      = kept_ff;
      pend_in      = pend_ff;
      rsp_in       = '0;

      if (cmd.push_commit) begin
         if (push_ok) begin
            write_ptr_in = next_slot(write_ptr_ff);
            if (full) begin
               read_ptr_in           = next_slot(read_ptr_ff);
               rsp_in.dropped_oldest = 1'b1;
            end else begin
               held_in = held_ff + 1'b1;
            end
            rsp_in.ok = 1'b1;
         end
         rsp_in.fill = FILL_W'(held_in);
      end

      if (cmd.read_commit) begin
         if (held_ff != '0) begin
            rsp_in.ok         = 1'b1;
            rsp_in.out_stream = rd_word_ff.stream;
            rsp_in.out_seq    = rd_word_ff.seq;
            rsp_in.out_time   = rd_word_ff.stamp;
            rsp_in.out_len    = rd_word_ff.len;
            rsp_in.out_data   = DATA_W'(rd_word_ff.data);
            if (req_ff.op == OP_POP) begin
               read_ptr_in = next_slot(read_ptr_ff);
               held_in     = held_ff - 1'b1;
            end
         end
         rsp_in.fill = FILL_W'(held_in);
      end

      // Compact kept frames toward the read pointer
      if (cmd.walk_start) begin
         rd_addr_in = read_ptr_ff;
         wr_addr_in = read_ptr_ff;
         rd_cnt_in  = '0;
         kept_in    = '0;
         pend_in    = 1'b0;
      end

      if (cmd.walk_step) begin
         pend_in = walk_more;
         if (walk_more) begin
            rd_addr_in = next_slot(rd_addr_ff);
            rd_cnt_in  = rd_cnt_ff + 1'b1;
         end
         if (walk_keep) begin
            wr_addr_in = next_slot(wr_addr_ff);
            kept_in    = kept_ff + 1'b1;
         end
      end

      if (cmd.purge_commit) begin
         held_in      = kept_ff;
         write_ptr_in = wr_addr_ff;
         pend_in      = 1'b0;
         rsp_in.ok    = 1'b1;
         rsp_in.fill  = FILL_W'(kept_ff);
      end
   end

   // Frame memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_word_ff <= mem[mem_ra];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) req_ff <= req_data;
      if (cmd.push_commit || cmd.read_commit || cmd.purge_commit) rsp_ff <= rsp_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      rd_cnt_ff  <= rd_cnt_in;
      kept_ff    <= kept_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff <= '0;
         read_ptr_ff  <= '0;
         held_ff      <= '0;
         pend_ff      <= 1'b0;
      end else begin
         write_ptr_ff <= write_ptr_in;
         read_ptr_ff  <= read_ptr_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/drop_oldest_frame_queue.sv */
// Drop-oldest frame queue: ring of DEPTH telemetry frames with push, pop,
// peek and per-stream purge. Top level joining dofq_ctrl and dofq_dp.
// Depends on dofq_pkg.
//
// Usage:
//   The req channel carries one operation word (push, pop, peek, purge);
//   the rsp channel returns exactly one result word per request. Both use
//   valid/stall; a word moves on a clock edge with valid high, stall low.
//   Push commits from the execute state; pop and peek add one registered
//   read of the frame memory; purge walks the held frames at one memory
//   read per cycle, writing back each kept frame, then retires the last
//   read, sees the walk end and commits the new fill.
//   One request is worked at a time; req_stall is low only in the idle
//   state. A result sits in the output register while rsp_stall is high;
//   the next request is taken meanwhile and finishes once that register
//   drains. A full-queue push overwrites the oldest frame and flags it.
//   Synchronous reset empties the queue and clears the output valid; the
//   frame memory is not cleared and needs no clearing pass.
`default_nettype none

module drop_oldest_frame_queue #(
   parameter int DEPTH         = dofq_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BYTES = dofq_pkg::PAYLOAD_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dofq_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dofq_pkg::rsp_type      rsp_data
);
   import dofq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence each word
   dofq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold frames and build results
   dofq_dp #(
      .DEPTH         (DEPTH),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
